[design/sfm_pkg.sv]
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types and register codes for the streaming first-match search.
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned START_W  = 16;
  localparam int unsigned APB_DW   = 64;
  localparam int unsigned APB_AW   = 5;

  // register index, taken from paddr[4:3] (8-byte spaced registers)
  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
    logic               length_overflow;
  } out_word_t;

endpackage

[design/sfm_cell.sv]
// ----------------------------------------------------------------------------
// sfm_cell
// One window position: holds a text byte and a fill flag, shifts them on
// each accepted word and checks the arriving byte against its pattern byte.
// ----------------------------------------------------------------------------
module sfm_cell #(
  parameter int unsigned NBYTES   = 16,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   shift_i,
  input  logic                                   clear_i,
  input  logic [sfm_pkg::BYTE_W-1:0]             byte_i,
  input  logic                                   vld_i,
  input  logic [NBYTES-1:0][sfm_pkg::BYTE_W-1:0] pattern_i,
  input  logic [sfm_pkg::LEN_W-1:0]              len_i,
  output logic [sfm_pkg::BYTE_W-1:0]             byte_o,
  output logic                                   vld_o,
  output logic                                   ok_o
);

  localparam int unsigned IDX_W = (NBYTES > 1) ? $clog2(NBYTES) : 1;
  localparam logic [sfm_pkg::LEN_W-1:0] KPOS = sfm_pkg::LEN_W'(CELL_IDX);
  localparam logic [sfm_pkg::LEN_W-1:0] KP1  = sfm_pkg::LEN_W'(CELL_IDX + 1);

  logic [sfm_pkg::BYTE_W-1:0] byte_q;
  logic                       vld_q;
  logic [sfm_pkg::LEN_W-1:0]  pidx;
  logic                       active;

  // this cell lines up with pattern byte len-1-k
  assign pidx   = len_i - KP1;
  assign active = (len_i > KPOS);
  assign ok_o   = !active || (vld_i && (byte_i == pattern_i[pidx[IDX_W-1:0]]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= clear_i ? 1'b0 : vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;

endmodule

[design/substring_first_match.sv]
// ----------------------------------------------------------------------------
// substring_first_match
// Streaming search for the first occurrence of a pattern of up to
// MAX_PATTERN bytes in a byte stream, one text byte per word.
// ----------------------------------------------------------------------------
// Use:
//   Input channel carries text_byte and last_byte; last_byte closes a text.
//   Output channel carries at most one word per text: found=1 with the start
//   offset of the first match, as soon as that match completes, or found=0
//   on the final byte when nothing matched. length_overflow reports that the
//   text ran past MAX_TEXT bytes (the position counter then saturates).
//   Pattern bytes and length are written over the APB port, 64-bit data,
//   registers at 0x00 (bytes 0..7), 0x08 (bytes 8..15), 0x10 (length).
// Timing:
//   One byte per cycle while not stalled. A result word appears in the cycle
//   after the byte that causes it. The window compare of all cells happens in
//   the cycle the byte is accepted, so the rate is set by that single pass.
// Stall:
//   The result sits in an output register; input is stalled only while that
//   register is full and the receiver stalls it.
// Reset:
//   Clears the window fill flags, counter, match and saturation flags and
//   the pattern registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
module substring_first_match #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned MAX_TEXT    = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // text in
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  sfm_pkg::in_word_t          in_word_i,
  // result out
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output sfm_pkg::out_word_t         out_word_o,
  // config
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfm_pkg::APB_AW-1:0] paddr,
  input  logic [sfm_pkg::APB_DW-1:0] pwdata,
  output logic [sfm_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned CNT_W = $clog2(MAX_TEXT + 1);
  localparam int unsigned SUB_W = (CNT_W > sfm_pkg::START_W) ? CNT_W : sfm_pkg::START_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT);
  localparam logic [sfm_pkg::LEN_W-1:0] LEN_MAX = sfm_pkg::LEN_W'(MAX_PATTERN);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [sfm_pkg::APB_DW-1:0] pat_lo_q, pat_hi_q;
  logic [sfm_pkg::LEN_W-1:0]  pat_len_q;
  sfm_pkg::reg_idx_e          reg_idx;
  logic                       cfg_wr;

  assign reg_idx = sfm_pkg::reg_idx_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        sfm_pkg::REG_PATTERN_LOW:    pat_lo_q  <= pwdata;
        sfm_pkg::REG_PATTERN_HIGH:   pat_hi_q  <= pwdata;
        sfm_pkg::REG_PATTERN_LENGTH: pat_len_q <= pwdata[sfm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfm_pkg::REG_PATTERN_LOW:    prdata = pat_lo_q;
      sfm_pkg::REG_PATTERN_HIGH:   prdata = pat_hi_q;
      sfm_pkg::REG_PATTERN_LENGTH: prdata = sfm_pkg::APB_DW'(pat_len_q);
      default:                     prdata = '0;
    endcase
  end

  // pattern as a byte array; only the first MAX_PATTERN bytes are ever used
  logic [2*sfm_pkg::APB_DW-1:0]                    pat_all;
  logic [MAX_PATTERN-1:0][sfm_pkg::BYTE_W-1:0]     pattern;

  assign pat_all = {pat_hi_q, pat_lo_q};
  assign pattern = pat_all[MAX_PATTERN*sfm_pkg::BYTE_W-1:0];

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic accept;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Window: chain of cells, cell 0 takes the newest byte
  // --------------------------------------------------------------------------
  logic [MAX_PATTERN-1:0][sfm_pkg::BYTE_W-1:0] cell_byte;
  logic [MAX_PATTERN-1:0]                      cell_vld;
  logic [MAX_PATTERN-1:0]                      cell_ok;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [sfm_pkg::BYTE_W-1:0] b_in;
    logic                       v_in;
    if (k == 0) begin : g_head
      assign b_in = in_word_i.text_byte;
      assign v_in = 1'b1;
    end else begin : g_body
      assign b_in = cell_byte[k-1];
      assign v_in = cell_vld[k-1];
    end
    sfm_cell #(
      .NBYTES   (MAX_PATTERN),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (accept),
      .clear_i   (in_word_i.last_byte),
      .byte_i    (b_in),
      .vld_i     (v_in),
      .pattern_i (pattern),
      .len_i     (pat_len_q),
      .byte_o    (cell_byte[k]),
      .vld_o     (cell_vld[k]),
      .ok_o      (cell_ok[k])
    );
  end

  // --------------------------------------------------------------------------
  // Position counter and per-text flags
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             sat_q, sat_d;
  logic             rep_q, rep_d;
  logic             match;
  logic             emit;
  logic [SUB_W-1:0] start_full;

  always_comb begin
    if (cnt_q == CNT_MAX) begin
      cnt_d = cnt_q;
      sat_d = 1'b1;
    end else begin
      cnt_d = cnt_q + CNT_W'(1);
      sat_d = sat_q;
    end
  end

  // cells past the length report ok; the fill flags cover "enough bytes yet"
  assign match = (pat_len_q != '0) && (pat_len_q <= LEN_MAX) && (&cell_ok);
  assign emit  = !rep_q && (match || in_word_i.last_byte);
  assign rep_d = rep_q || match;

  assign start_full = SUB_W'(cnt_d) - SUB_W'(pat_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sat_q <= 1'b0;
      rep_q <= 1'b0;
    end else if (accept) begin
      if (in_word_i.last_byte) begin
        cnt_q <= '0;
        sat_q <= 1'b0;
        rep_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        sat_q <= sat_d;
        rep_q <= rep_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic               out_vld_q;
  sfm_pkg::out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= emit;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_q.found           <= match;
      out_q.match_start     <= match ? start_full[sfm_pkg::START_W-1:0] : '0;
      out_q.length_overflow <= sat_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

[design/sfm_checker.sv]
// ----------------------------------------------------------------------------
// sfm_checker
// Port-level checks for the first-match search, bound to the top level.
// ----------------------------------------------------------------------------
module sfm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sfm_pkg::out_word_t out_word_o
);

  // a held result word keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // input only backs up behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a fresh result always follows an accepted text byte
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without a preceding text byte");

  // not-found words carry a zero offset
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.found |-> out_word_o.match_start == '0)
    else $error("non-zero offset on a not-found word");

endmodule

bind substring_first_match sfm_checker u_sfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

[dv/substring_first_match_tb.sv]
// ----------------------------------------------------------------------------
// substring_first_match_tb
// Self-checking bench for the streaming first-match search. Text words go
// in through a valid/stall driver and result words are checked, field by
// field, against an in-bench model of the window compare. The pattern
// registers are rewritten over APB between phases. The sender and receiver
// idle at random, and one phase runs with no random idling.
// ----------------------------------------------------------------------------
module substring_first_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PAT        = 16;
  localparam int unsigned MAX_TXT        = 65536;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned DRAIN_TAIL     = 4;    // result word is registered behind its byte
  localparam int unsigned RX_HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int unsigned QUIET_LIMIT    = 4000; // cycles with no word moved and no APB access
  localparam int unsigned BATCH_WORDS    = 80;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  logic                        text_valid = 1'b0;
  logic                        text_stall;
  sfm_pkg::in_word_t           text_word  = '0;
  logic                        res_valid;
  logic                        res_stall  = 1'b0;
  sfm_pkg::out_word_t          res_word;
  logic                        psel       = 1'b0;
  logic                        penable    = 1'b0;
  logic                        pwrite     = 1'b0;
  logic [sfm_pkg::APB_AW-1:0]  paddr      = '0;
  logic [sfm_pkg::APB_DW-1:0]  pwdata     = '0;
  logic [sfm_pkg::APB_DW-1:0]  prdata;
  logic                        pready;

  substring_first_match #(
    .MAX_PATTERN(MAX_PAT),
    .MAX_TEXT   (MAX_TXT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (text_valid),
    .in_stall_o (text_stall),
    .in_word_i  (text_word),
    .out_valid_o(res_valid),
    .out_stall_i(res_stall),
    .out_word_o (res_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  sfm_pkg::in_word_t   text_pending [$];   // words waiting for the driver
  sfm_pkg::out_word_t  results_due  [$];   // predicted result words, oldest first

  // mirror of the pattern registers; byte i of the pattern sits at [8i+:8]
  logic [127:0] pat_mirror = '0;
  logic [4:0]   len_mirror = '0;

  // search model state, entry 0 of the window is the newest byte
  logic [7:0]   win_bytes [MAX_PAT];
  logic [16:0]  seen_count = '0;
  logic         match_done = 1'b0;
  logic         count_sat  = 1'b0;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_reqs     = 0;   // bumped by the sequencer
  int unsigned  hold_served   = 0;   // bumped by the receiver process
  int unsigned  hold_left     = 0;
  int unsigned  quiet_cycles  = 0;

  int unsigned  words_in      = 0;
  int unsigned  results_seen  = 0;
  int unsigned  found_seen    = 0;
  int unsigned  sat_seen      = 0;
  int unsigned  cfg_writes    = 0;
  int unsigned  faults        = 0;

  initial foreach (win_bytes[i]) win_bytes[i] = '0;

  // --------------------------------------------------------------------------
  // Search model: one text byte in, zero or one result word out
  // --------------------------------------------------------------------------
  function automatic void search_step(sfm_pkg::in_word_t w);
    logic               hit;
    sfm_pkg::out_word_t r;
    hit = 1'b0;
    r   = '0;

    for (int i = MAX_PAT - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = w.text_byte;

    // position counter holds at the bound once it gets there
    if (seen_count >= MAX_TXT) begin
      seen_count = 17'(MAX_TXT);
      count_sat  = 1'b1;
    end else begin
      seen_count = seen_count + 1'b1;
    end

    // length 0 and lengths above the window never match
    if (len_mirror != 0 && len_mirror <= MAX_PAT && seen_count >= len_mirror) begin
      hit = 1'b1;
      for (int i = 0; i < len_mirror; i++)
        if (win_bytes[len_mirror-1-i] != pat_mirror[8*i +: 8]) hit = 1'b0;
    end

    if (!match_done && hit) begin
      match_done        = 1'b1;
      r.found           = 1'b1;
      r.match_start     = sfm_pkg::START_W'(seen_count - len_mirror);
      r.length_overflow = count_sat;
      results_due.push_back(r);
    end else if (w.last_byte && !match_done) begin
      r.length_overflow = count_sat;
      results_due.push_back(r);
    end

    // final byte closes the text
    if (w.last_byte) begin
      foreach (win_bytes[i]) win_bytes[i] = '0;
      seen_count = '0;
      match_done = 1'b0;
      count_sat  = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Text driver: offers the next pending word, holds it until taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : text_driver
    logic took;
    if (!rst_ni) begin
      text_valid <= 1'b0;
      text_word  <= '0;
    end else begin
      took = text_valid && !text_stall;
      if (took) begin
        search_step(text_word);
        words_in++;
      end
      if (!text_valid || took) begin
        if (text_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          text_word  <= text_pending.pop_front();
          text_valid <= 1'b1;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall plus a long hold-off counted here on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_stall
    int unsigned next_hold;
    if (!rst_ni) begin
      res_stall   <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else begin
      next_hold = hold_left;
      if (next_hold != 0) begin
        next_hold--;
      end else if (hold_served != hold_reqs) begin
        next_hold = RX_HOLD_CYCLES;
        hold_served <= hold_served + 1;
      end
      hold_left <= next_hold;
      res_stall <= (next_hold != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every accepted word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    sfm_pkg::out_word_t want;
    if (rst_ni && res_valid && !res_stall) begin
      results_seen++;
      if (res_word.found === 1'b1) found_seen++;
      if (res_word.length_overflow === 1'b1) sat_seen++;
      if (results_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected result found=%b start=%0d ovf=%b", $realtime,
                   res_word.found, res_word.match_start, res_word.length_overflow);
      end else begin
        want = results_due.pop_front();
        if (res_word.found !== want.found ||
            res_word.match_start !== want.match_start ||
            res_word.length_overflow !== want.length_overflow) begin
          faults++;
          if (faults <= 10)
            $display("%0t: exp found=%b start=%0d ovf=%b, got found=%b start=%0d ovf=%b",
                     $realtime, want.found, want.match_start, want.length_overflow,
                     res_word.found, res_word.match_start, res_word.length_overflow);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if nothing moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (text_valid && !text_stall) || (res_valid && !res_stall) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results still due",
               QUIET_LIMIT, results_due.size());
      $display("** substring_first_match: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer helpers
  // --------------------------------------------------------------------------
  task automatic push_word(logic [7:0] b, logic l);
    text_pending.push_back('{text_byte: b, last_byte: l});
  endtask

  // APB write: setup cycle then access cycle, taken when pready is high
  task automatic cfg_write(sfm_pkg::reg_idx_e idx, logic [sfm_pkg::APB_DW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
  endtask

  // only called with the block idle; ends on a falling edge
  task automatic set_pattern(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    cfg_write(sfm_pkg::REG_PATTERN_LOW, lo);
    cfg_write(sfm_pkg::REG_PATTERN_HIGH, hi);
    cfg_write(sfm_pkg::REG_PATTERN_LENGTH, sfm_pkg::APB_DW'(len));
    pat_mirror = {hi, lo};
    len_mirror = len;
    @(negedge clk_i);
  endtask

  // wait until every queued word is in and every result is out
  task automatic drain();
    do @(negedge clk_i);
    while (text_pending.size() != 0 || text_valid || results_due.size() != 0);
    repeat (DRAIN_TAIL) @(negedge clk_i);
  endtask

  // random pattern, mostly short lengths so that matches are common
  task automatic pick_config();
    int unsigned r;
    logic [4:0]  len;
    r = $urandom_range(19);
    if (r == 0)       len = 5'd0;
    else if (r <= 12) len = 5'($urandom_range(4, 1));
    else if (r <= 15) len = 5'($urandom_range(15, 5));
    else if (r == 16) len = 5'(MAX_PAT);
    else if (r <= 18) len = 5'($urandom_range(30, 17));
    else              len = 5'd31;
    set_pattern({$urandom, $urandom}, {$urandom, $urandom}, len);
  endtask

  // text biased toward pattern bytes, with the pattern planted on request
  task automatic queue_text(int unsigned n, bit plant, bit close);
    logic [7:0]  chars [$];
    int unsigned k;
    int unsigned at;
    for (int unsigned i = 0; i < n; i++) begin
      k = $urandom_range(15);
      chars.push_back($urandom_range(1) ? pat_mirror[8*k +: 8] : 8'($urandom));
    end
    if (plant && len_mirror != 0 && len_mirror <= MAX_PAT && n >= len_mirror) begin
      at = $urandom_range(n - len_mirror);
      for (int unsigned i = 0; i < len_mirror; i++) chars[at+i] = pat_mirror[8*i +: 8];
    end
    foreach (chars[i]) push_word(chars[i], close && (i == chars.size() - 1));
  endtask

  // mostly well-formed texts, some noise; may leave a text open at the end
  task automatic queue_batch(int unsigned words);
    int unsigned made;
    int unsigned n;
    made = 0;
    while (made < words) begin
      if ($urandom_range(99) < 85) begin
        n = $urandom_range(30, 1);
        queue_text(n, $urandom_range(99) < 60, $urandom_range(99) < 90);
      end else begin
        n = $urandom_range(8, 1);
        for (int unsigned i = 0; i < n; i++) push_word(8'($urandom), $urandom_range(7) == 0);
      end
      made += n;
    end
    if ($urandom_range(1)) queue_text($urandom_range(5, 1), 1'b0, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin : sequencer
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part under the first idling mix
    send_idle_pct = 35;
    recv_idle_pct = 70;

    // reset pattern has length zero: the text ends not found
    push_word(8'h41, 1'b0);
    push_word(8'h42, 1'b1);
    drain();

    // full-length pattern holding 00 and FF, match lands on the final byte
    set_pattern(64'h8877_6655_4433_2211, 64'h00FF_EEDD_CCBB_AA99, 5'(MAX_PAT));
    for (int i = 0; i < MAX_PAT; i++) push_word(pat_mirror[8*i +: 8], i == MAX_PAT - 1);
    drain();

    // single zero byte: hit on the first byte, later bytes stay silent
    set_pattern(64'h0, '1, 5'd1);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b1);
    drain();

    // text shorter than the pattern, then a fresh text must not see the old window
    set_pattern(64'h0000_0000_0063_6261, 64'h0, 5'd3);
    push_word(8'h61, 1'b0);
    push_word(8'h62, 1'b1);
    push_word(8'h63, 1'b1);
    drain();

    // lengths beyond the window never match
    set_pattern(64'h61, 64'h0, 5'd17);
    push_word(8'h61, 1'b1);
    drain();
    set_pattern(64'h61, 64'h0, 5'd31);
    push_word(8'h61, 1'b1);
    drain();

    // pattern swapped mid-text, new one applies from the next compare
    set_pattern(64'h0062_6178, 64'h0, 5'd3);
    push_word(8'h61, 1'b0);
    drain();
    set_pattern(64'h6261, 64'h0, 5'd2);
    push_word(8'h62, 1'b1);
    drain();

    // random part: three idling mixes, several patterns each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int c = 0; c < 4; c++) begin
        pick_config();
        if (mode == 1 && c == 1) begin
          // sender stops mid-phase until the results have all come back
          queue_batch(BATCH_WORDS / 2);
          drain();
          queue_batch(BATCH_WORDS / 2);
        end else begin
          queue_batch(BATCH_WORDS);
          // long receiver hold while words keep coming: the block backs up
          if ((mode == 2 && c == 0) || (mode == 0 && c == 2)) hold_reqs++;
        end
        drain();
      end
    end

    if (results_due.size() != 0) begin
      faults += results_due.size();
      $display("%0d predicted results never arrived", results_due.size());
    end

    $display("covered %0d text words, %0d results (%0d found, %0d past the bound)",
             words_in, results_seen, found_seen, sat_seen);
    $display("%0d register writes, %0d faults", cfg_writes, faults);
    if (faults == 0) begin
      $display("** substring_first_match: PASSED **");
    end else begin
      $display("** substring_first_match: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sfm_pkg.sv
design/sfm_cell.sv
design/substring_first_match.sv
design/sfm_checker.sv
dv/substring_first_match_tb.sv
